FILE: design/tied_vocab_projection_mac_defines.svh
// assertion macros for the tied vocabulary projection block
// used by the port checker; expects clk and rst_n in the enclosing scope
`ifndef TIED_VOCAB_PROJECTION_MAC_DEFINES_SVH
`define TIED_VOCAB_PROJECTION_MAC_DEFINES_SVH

// implication in the same cycle, off during reset
`define TVPM_AST_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tvpm check failed");

// implication into the next cycle, off during reset
`define TVPM_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tvpm check failed");

// state seen in the cycle after a reset edge
`define TVPM_AST_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("tvpm reset check failed");

`endif

FILE: design/tvpm_pkg.sv
// shared types, codes and helpers for the tied vocabulary projection block
// no dependencies
package tvpm_pkg;

  localparam int DIM   = 64;
  localparam int VOCAB = 256;

  localparam int OP_W      = 3;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 6;
  localparam int VAL_W     = 16;
  localparam int RES_W     = 32;
  localparam int DIMC_W    = 7;
  localparam int VOCC_W    = 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOCAB = 1'b1;

  localparam logic [DIMC_W-1:0] DIM_CFG_RST   = 7'd64;
  localparam logic [VOCC_W-1:0] VOCAB_CFG_RST = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_W  = 3'd0,
    OP_LOAD_X   = 3'd1,
    OP_LOGIT    = 3'd2,
    OP_GRAD     = 3'd3,
    OP_READ_DX  = 3'd4,
    OP_READ_WG  = 3'd5,
    OP_CLEAR_WG = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic wr_w;
    logic wr_x;
    logic sweep_start;
    logic issue;
    logic rd_single;
    logic clr_wg;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bad;
    logic            issue_last;
    logic            pipe_empty;
    logic            out_free;
  } dp_sts_t;

  // signed add with clip to 32 bits, returns {clipped, value}
  function automatic logic [RES_W:0] sat_add(input logic signed [RES_W-1:0] a,
                                             input logic signed [RES_W-1:0] b);
    logic signed [RES_W:0] s;
    s = {a[RES_W-1], a} + {b[RES_W-1], b};
    if (s[RES_W] != s[RES_W-1]) begin
      sat_add = {1'b1, s[RES_W], {(RES_W-1){~s[RES_W]}}};
    end else begin
      sat_add = {1'b0, s[RES_W-1:0]};
    end
  endfunction

endpackage

FILE: design/tvpm_ctrl.sv
// sequencing state machine for the tied vocabulary projection block
// depends on tvpm_pkg; drives the datapath through dp_cmd_t
module tvpm_ctrl import tvpm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_FINISH;
        if (!sts.bad) begin
          case (sts.op)
            OP_WRITE_W: begin
              cmd.wr_w = 1'b1;
            end
            OP_LOAD_X: begin
              cmd.wr_x = 1'b1;
            end
            OP_LOGIT, OP_GRAD: begin
              cmd.sweep_start = 1'b1;
              state_nxt       = ST_SWEEP;
            end
            OP_READ_DX, OP_READ_WG: begin
              cmd.rd_single = 1'b1;
            end
            OP_CLEAR_WG: begin
              cmd.clr_wg = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/tvpm_dp.sv
// datapath: item registers, tables, element pipeline and result register
// depends on tvpm_pkg; commanded by tvpm_ctrl
module tvpm_dp import tvpm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  logic [OP_W-1:0]         in_op,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [COL_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [DIMC_W-1:0]       dim_cfg,
  input  logic [VOCC_W-1:0]       vocab_cfg,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [RES_W-1:0] out_result,
  output logic                    out_saturated,
  output logic                    out_bad_index
);

  localparam int DW     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CW     = $clog2(DIM + 1);
  localparam int VW     = (VOCAB > 1) ? $clog2(VOCAB) : 1;
  localparam int VOC_CW = $clog2(VOCAB + 1);
  localparam int AW     = (VOCAB * DIM > 1) ? $clog2(VOCAB * DIM) : 1;
  localparam int ACC_W  = RES_W + CW + 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-64'sd2147483648);

  // item registers
  logic [OP_W-1:0]         op_r;
  logic [ROW_W-1:0]        row_r;
  logic [COL_W-1:0]        col_r;
  logic signed [VAL_W-1:0] val_r;
  logic [AW-1:0]           row_base_r;

  logic [CW-1:0]     nd;
  logic [VOC_CW-1:0] nv;
  logic              row_ok, col_ok, bad, is_grad;
  logic [VW-1:0]     rix;
  logic [DW-1:0]     cix;

  // tables
  logic signed [VAL_W-1:0] w_mem  [VOCAB*DIM];
  logic signed [VAL_W-1:0] x_mem  [DIM];
  logic signed [RES_W-1:0] dx_mem [DIM];
  logic signed [RES_W-1:0] wg_mem [VOCAB*DIM];
  logic [DIM-1:0]          dx_vld_r;
  logic [VOCAB-1:0]        wg_vld_r;

  // sweep control
  logic [CW-1:0] cnt_r, len_r, sweep_len;
  logic          wgv_r;

  // read port
  logic [DW-1:0]           elem;
  logic [AW-1:0]           rd_addr;
  logic                    rd_en;
  logic signed [VAL_W-1:0] w_q, x_q;
  logic signed [RES_W-1:0] wg_q, dx_q;
  logic                    dxv_q;

  // element pipeline
  logic                    s1_vld_r, s1_use_r, s2_vld_r, s2_use_r;
  logic [DW-1:0]           s1_d_r, s2_d_r;
  logic [AW-1:0]           s1_a_r, s2_a_r;
  logic signed [VAL_W-1:0] opnd;
  logic signed [RES_W-1:0] mul_a, mul_b, old_wg, old_dx;
  logic signed [RES_W-1:0] pa_r, pb_r, owg_r, odx_r;
  logic signed [RES_W-1:0] gw, gx;
  logic                    gw_clip, gx_clip;
  logic signed [ACC_W-1:0] acc_r;
  logic                    sat_r;

  // dx write port
  logic                    dx_we;
  logic [DW-1:0]           dx_wa;
  logic signed [RES_W-1:0] dx_wd;

  // result
  logic signed [RES_W-1:0] logit_res, res_nxt;
  logic                    logit_sat, sat_nxt;
  logic                    out_valid_r;
  logic signed [RES_W-1:0] out_result_r;
  logic                    out_saturated_r, out_bad_index_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_op;
      row_r      <= in_row;
      col_r      <= in_col;
      val_r      <= in_value;
      row_base_r <= AW'(32'(in_row) * DIM);
    end
  end

  // sizes in use, clamped to the built sizes
  always_comb begin
    if (dim_cfg == '0) begin
      nd = CW'(1);
    end else if (32'(dim_cfg) > DIM) begin
      nd = CW'(DIM);
    end else begin
      nd = CW'(dim_cfg);
    end
    if (vocab_cfg == '0) begin
      nv = VOC_CW'(1);
    end else if (32'(vocab_cfg) > VOCAB) begin
      nv = VOC_CW'(VOCAB);
    end else begin
      nv = VOC_CW'(vocab_cfg);
    end
  end

  assign row_ok  = 32'(row_r) < 32'(nv);
  assign col_ok  = 32'(col_r) < 32'(nd);
  assign rix     = VW'(row_r);
  assign cix     = DW'(col_r);
  assign is_grad = (op_r == OP_GRAD);

  always_comb begin
    case (op_r)
      OP_WRITE_W, OP_READ_WG: bad = !(row_ok && col_ok);
      OP_LOAD_X, OP_READ_DX:  bad = !col_ok;
      OP_LOGIT, OP_GRAD:      bad = !row_ok;
      OP_CLEAR_WG:            bad = 1'b0;
      default:                bad = 1'b1;
    endcase
  end

  // a row with no gradient since the last clear is swept in full to zero its tail
  assign sweep_len = (is_grad && !wg_vld_r[rix]) ? CW'(DIM) : nd;

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      cnt_r <= '0;
      len_r <= sweep_len;
      wgv_r <= wg_vld_r[rix];
    end else if (cmd.issue) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign elem    = cmd.issue ? DW'(cnt_r) : cix;
  assign rd_addr = row_base_r + AW'(elem);
  assign rd_en   = cmd.issue | cmd.rd_single;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      w_q   <= w_mem[rd_addr];
      x_q   <= x_mem[elem];
      wg_q  <= wg_mem[rd_addr];
      dx_q  <= dx_mem[elem];
      dxv_q <= dx_vld_r[elem];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_w) begin
      w_mem[row_base_r + AW'(cix)] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_x) begin
      x_mem[cix] <= val_r;
    end
  end

  always_comb begin
    if (cmd.wr_x) begin
      dx_we = 1'b1;
      dx_wa = cix;
      dx_wd = '0;
    end else begin
      dx_we = s2_vld_r && is_grad && s2_use_r;
      dx_wa = s2_d_r;
      dx_wd = gx;
    end
  end

  always_ff @(posedge clk) begin
    if (dx_we) begin
      dx_mem[dx_wa] <= dx_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && is_grad) begin
      wg_mem[s2_a_r] <= gw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_vld_r <= '0;
      wg_vld_r <= '0;
    end else begin
      if (dx_we) begin
        dx_vld_r[dx_wa] <= 1'b1;
      end
      if (cmd.clr_wg) begin
        wg_vld_r <= '0;
      end else if (cmd.sweep_start && is_grad) begin
        wg_vld_r[rix] <= 1'b1;
      end
    end
  end

  // stage 1: read data back, multiply
  assign old_wg = wgv_r ? wg_q : '0;
  assign old_dx = dxv_q ? dx_q : '0;
  assign opnd   = is_grad ? val_r : w_q;
  assign mul_a  = RES_W'(x_q) * RES_W'(opnd);
  assign mul_b  = RES_W'(w_q) * RES_W'(val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_use_r <= cnt_r < nd;
      s1_d_r   <= DW'(cnt_r);
      s1_a_r   <= rd_addr;
    end
    if (s1_vld_r) begin
      s2_use_r <= s1_use_r;
      s2_d_r   <= s1_d_r;
      s2_a_r   <= s1_a_r;
      pa_r     <= s1_use_r ? mul_a : '0;
      pb_r     <= s1_use_r ? mul_b : '0;
      owg_r    <= old_wg;
      odx_r    <= old_dx;
    end
  end

  // stage 2: accumulate or update
  assign {gw_clip, gw} = sat_add(owg_r, pa_r);
  assign {gx_clip, gx} = sat_add(odx_r, pb_r);

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + ACC_W'(pa_r);
      if (is_grad) begin
        sat_r <= sat_r | gw_clip | gx_clip;
      end
    end
  end

  always_comb begin
    if (acc_r > ACC_MAX) begin
      logit_res = ACC_MAX[RES_W-1:0];
      logit_sat = 1'b1;
    end else if (acc_r < ACC_MIN) begin
      logit_res = ACC_MIN[RES_W-1:0];
      logit_sat = 1'b1;
    end else begin
      logit_res = acc_r[RES_W-1:0];
      logit_sat = 1'b0;
    end
  end

  always_comb begin
    res_nxt = '0;
    sat_nxt = 1'b0;
    if (!bad) begin
      case (op_r)
        OP_LOGIT: begin
          res_nxt = logit_res;
          sat_nxt = logit_sat;
        end
        OP_GRAD: begin
          sat_nxt = sat_r;
        end
        OP_READ_DX: begin
          res_nxt = dxv_q ? dx_q : '0;
        end
        OP_READ_WG: begin
          res_nxt = wg_vld_r[rix] ? wg_q : '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_r    <= res_nxt;
      out_saturated_r <= sat_nxt;
      out_bad_index_r <= bad;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result    = out_result_r;
  assign out_saturated = out_saturated_r;
  assign out_bad_index = out_bad_index_r;

  assign sts.op         = op_r;
  assign sts.bad        = bad;
  assign sts.issue_last = (cnt_r == len_r - CW'(1));
  assign sts.pipe_empty = !s1_vld_r && !s2_vld_r;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

FILE: design/tied_vocab_projection_mac.sv
// tied vocabulary projection: weight table, input vector, dx and weight gradients
// depends on tvpm_pkg, tvpm_ctrl and tvpm_dp
// input channel: in_valid/in_ready carry one op beat (op, row, col, value)
// result channel: out_valid/out_ready carry one result beat per op
// config port: cfg_we with cfg_index 0 (dim in use) or 1 (vocab in use)
// one op at a time; writes, loads, reads and clear pass decode and finish
// states, and the next beat can be taken in the cycle the result appears
// logit and apply-gradient stream one element per cycle through a single
// multiply-accumulate pipeline and wait for it to drain; the next beat is
// takeable in the cycle the result appears; a gradient on a row untouched
// since the last clear walks all DIM elements instead
// reset clears dx and all weight gradients at once through valid bits,
// config returns to 64 and 256; weights and x stay undefined until written
// a stalled result sits in the output register; the next input beat is
// still taken and worked on, and waits to finish until the result is taken
module tied_vocab_projection_mac import tvpm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_op,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [COL_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RES_W-1:0] out_result,
  output logic                    out_saturated,
  output logic                    out_bad_index
);

  logic [DIMC_W-1:0] dim_cfg_r;
  logic [VOCC_W-1:0] vocab_cfg_r;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_cfg_r   <= DIM_CFG_RST;
      vocab_cfg_r <= VOCAB_CFG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIM:   dim_cfg_r   <= cfg_data[DIMC_W-1:0];
        CFG_VOCAB: vocab_cfg_r <= cfg_data[VOCC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tvpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tvpm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_value      (in_value),
    .dim_cfg       (dim_cfg_r),
    .vocab_cfg     (vocab_cfg_r),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_result    (out_result),
    .out_saturated (out_saturated),
    .out_bad_index (out_bad_index)
  );

endmodule

FILE: design/tvpm_chk.sv
// port-level checker for the tied vocabulary projection block, bound to the top
// depends on tvpm_pkg and tied_vocab_projection_mac_defines.svh
`include "tied_vocab_projection_mac_defines.svh"
module tvpm_chk import tvpm_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [RES_W-1:0] out_result,
  input logic                    out_saturated,
  input logic                    out_bad_index
);

  // stalled result beat holds
  `TVPM_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result) && $stable(out_saturated) && $stable(out_bad_index))

  // a rejected op reports nothing else
  `TVPM_AST_SAME(a_bad_clean, out_valid && out_bad_index, out_result == 32'sd0 && !out_saturated)

  // one op in flight: no second beat straight after an accepted one
  `TVPM_AST_NEXT(a_one_op, in_valid && in_ready, !in_ready)

  // out of reset: ready for input, nothing to deliver
  `TVPM_AST_RST(a_rst_idle, in_ready && !out_valid)

endmodule

bind tied_vocab_projection_mac tvpm_chk u_chk (.*);

FILE: sim/tb_tied_vocab_projection_mac.sv
// testbench for tied_vocab_projection_mac: directed and random op beats, each checked
// against a built-in forward/backward projection predictor
// depends on tvpm_pkg and the block's RTL; needs no files or arguments
module tb_tied_vocab_projection_mac;
  import tvpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_N   = 64;
  localparam int VOCAB_N = 256;
  localparam logic [OP_W-1:0] OP_UNDEF = 3'd7;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } op_beat_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic                    saturated;
    logic                    bad_index;
  } proj_res_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_DIM;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         in_op = '0;
  logic [ROW_W-1:0]        in_row = '0;
  logic [COL_W-1:0]        in_col = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [RES_W-1:0] out_result;
  logic                    out_saturated;
  logic                    out_bad_index;

  logic in_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  op_beat_t  op_backlog [$];
  proj_res_t awaited [$];

  // predictor state
  logic signed [15:0] weights_q88 [VOCAB_N*DIM_N];
  logic signed [15:0] x_q88 [DIM_N];
  logic signed [31:0] dx_q16 [DIM_N];
  logic signed [31:0] wgrad_q16 [VOCAB_N*DIM_N];
  logic [DIMC_W-1:0]  dim_cfg = DIM_CFG_RST;
  logic [VOCC_W-1:0]  vocab_cfg = VOCAB_CFG_RST;

  // stimulus bookkeeping
  bit weight_written [VOCAB_N*DIM_N];
  bit x_written [DIM_N];
  int gen_dim_raw = 64;
  int gen_vocab_raw = 256;
  int useful_items = 0;

  int fail_count = 0;
  int results_checked = 0;
  int sat_seen = 0;
  int bad_seen = 0;
  int logits_seen = 0;
  int settings_used = 0;

  tied_vocab_projection_mac DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_row(in_row), .in_col(in_col), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result(out_result), .out_saturated(out_saturated), .out_bad_index(out_bad_index)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int dim_eff(input int raw);
    if (raw < 1) return 1;
    if (raw > DIM_N) return DIM_N;
    return raw;
  endfunction

  function automatic int vocab_eff(input int raw);
    if (raw < 1) return 1;
    if (raw > VOCAB_N) return VOCAB_N;
    return raw;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v, inout logic hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic proj_res_t project_beat(input op_beat_t b);
    proj_res_t r;
    int        nd;
    int        nv;
    int        k;
    logic      row_ok;
    logic      col_ok;
    logic      hit;
    longint    acc;
    longint    gw;
    longint    gx;
    r = '0;
    hit = 1'b0;
    nd = dim_eff(int'(dim_cfg));
    nv = vocab_eff(int'(vocab_cfg));
    row_ok = int'(b.row) < nv;
    col_ok = int'(b.col) < nd;
    case (b.op)
      OP_WRITE_W: begin
        if (row_ok && col_ok) weights_q88[int'(b.row)*DIM_N + int'(b.col)] = b.value;
        else r.bad_index = 1'b1;
      end
      OP_LOAD_X: begin
        if (col_ok) begin
          x_q88[b.col] = b.value;
          dx_q16[b.col] = '0;
        end else r.bad_index = 1'b1;
      end
      OP_LOGIT: begin
        if (row_ok) begin
          acc = 0;
          for (int d = 0; d < nd; d++)
            acc += longint'(weights_q88[int'(b.row)*DIM_N + d]) * longint'(x_q88[d]);
          r.result = clip32(acc, hit);
        end else r.bad_index = 1'b1;
      end
      OP_GRAD: begin
        if (row_ok) begin
          for (int d = 0; d < nd; d++) begin
            k = int'(b.row)*DIM_N + d;
            gw = longint'(wgrad_q16[k]) + longint'(x_q88[d]) * longint'(b.value);
            gx = longint'(dx_q16[d]) + longint'(weights_q88[k]) * longint'(b.value);
            wgrad_q16[k] = clip32(gw, hit);
            dx_q16[d] = clip32(gx, hit);
          end
        end else r.bad_index = 1'b1;
      end
      OP_READ_DX: begin
        if (col_ok) r.result = dx_q16[b.col];
        else r.bad_index = 1'b1;
      end
      OP_READ_WG: begin
        if (row_ok && col_ok) r.result = wgrad_q16[int'(b.row)*DIM_N + int'(b.col)];
        else r.bad_index = 1'b1;
      end
      OP_CLEAR_WG: begin
        foreach (wgrad_q16[i]) wgrad_q16[i] = '0;
      end
      default: r.bad_index = 1'b1;
    endcase
    r.saturated = hit && !r.bad_index;
    if (r.bad_index) r.result = '0;
    return r;
  endfunction

  always @(negedge clk) begin : drive_beats
    op_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid || in_taken) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = op_backlog.pop_front();
          in_valid <= 1'b1;
          in_op <= nxt.op;
          in_row <= nxt.row;
          in_col <= nxt.col;
          in_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_beats
    proj_res_t want;
    op_beat_t  seen;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_we) begin
        if (cfg_index == CFG_DIM) dim_cfg = cfg_data[DIMC_W-1:0];
        else if (cfg_index == CFG_VOCAB) vocab_cfg = cfg_data[VOCC_W-1:0];
      end
      if (in_valid && in_ready) begin
        seen = '{in_op, in_row, in_col, in_value};
        awaited.push_back(project_beat(seen));
        if (in_op == OP_LOGIT) logits_seen++;
      end
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result beat with nothing awaited: result %0d", out_result);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          results_checked++;
          if (out_saturated) sat_seen++;
          if (out_bad_index) bad_seen++;
          if (out_result !== want.result) begin
            $error("result: expected %0d, got %0d", want.result, out_result);
            fail_count++;
          end
          if (out_saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, out_saturated);
            fail_count++;
          end
          if (out_bad_index !== want.bad_index) begin
            $error("bad_index: expected %0b, got %0b", want.bad_index, out_bad_index);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic logic signed [15:0] q88_value();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      3: return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] pick_row(input bit hot);
    int nv;
    nv = vocab_eff(gen_vocab_raw);
    if ($urandom_range(9) == 0) return ROW_W'($urandom_range(VOCAB_N-1));
    if (hot) return ROW_W'($urandom_range((nv < 4 ? nv : 4) - 1));
    return ROW_W'($urandom_range(nv - 1));
  endfunction

  function automatic logic [COL_W-1:0] pick_col();
    if ($urandom_range(9) == 0) return COL_W'($urandom_range(DIM_N-1));
    return COL_W'($urandom_range(dim_eff(gen_dim_raw) - 1));
  endfunction

  task automatic queue_op(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                          input logic [COL_W-1:0] col, input logic signed [VAL_W-1:0] val);
    int nd;
    int nv;
    bit row_ok;
    bit col_ok;
    bit rejected;
    nd = dim_eff(gen_dim_raw);
    nv = vocab_eff(gen_vocab_raw);
    row_ok = int'(row) < nv;
    col_ok = int'(col) < nd;
    case (op)
      OP_WRITE_W, OP_READ_WG: rejected = !(row_ok && col_ok);
      OP_LOAD_X, OP_READ_DX:  rejected = !col_ok;
      OP_LOGIT, OP_GRAD:      rejected = !row_ok;
      OP_CLEAR_WG:            rejected = 1'b0;
      default:                rejected = 1'b1;
    endcase
    if (!rejected && op == OP_WRITE_W) weight_written[int'(row)*DIM_N + int'(col)] = 1'b1;
    if (!rejected && op == OP_LOAD_X) x_written[col] = 1'b1;
    if (!rejected) useful_items++;
    op_backlog.push_back('{op, row, col, val});
  endtask

  // fill in any weight of the row and any x element still unwritten
  task automatic prime_row(input logic [ROW_W-1:0] row);
    int nd;
    nd = dim_eff(gen_dim_raw);
    if (int'(row) < vocab_eff(gen_vocab_raw)) begin
      for (int d = 0; d < nd; d++) begin
        if (!x_written[d]) queue_op(OP_LOAD_X, ROW_W'($urandom), COL_W'(d), q88_value());
        if (!weight_written[int'(row)*DIM_N + d])
          queue_op(OP_WRITE_W, row, COL_W'(d), q88_value());
      end
    end
  endtask

  task automatic random_burst(input int n);
    int                target;
    int                pick;
    logic [ROW_W-1:0]  r;
    target = useful_items + n;
    while (useful_items < target) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        queue_op(OP_WRITE_W, pick_row(1'b0), pick_col(), q88_value());
      end else if (pick < 34) begin
        queue_op(OP_LOAD_X, ROW_W'($urandom), pick_col(), q88_value());
      end else if (pick < 52) begin
        r = pick_row(1'b1);
        prime_row(r);
        queue_op(OP_LOGIT, r, COL_W'($urandom), VAL_W'($urandom));
      end else if (pick < 70) begin
        r = pick_row(1'b1);
        prime_row(r);
        queue_op(OP_GRAD, r, COL_W'($urandom), q88_value());
      end else if (pick < 80) begin
        queue_op(OP_READ_DX, ROW_W'($urandom), pick_col(), VAL_W'($urandom));
      end else if (pick < 92) begin
        queue_op(OP_READ_WG, pick_row(1'b1), pick_col(), VAL_W'($urandom));
      end else if (pick < 94) begin
        queue_op(OP_CLEAR_WG, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
      end else if (pick < 97) begin
        queue_op(OP_UNDEF, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
      end else begin
        queue_op(OP_READ_WG, pick_row(1'b0), pick_col(), VAL_W'($urandom));
      end
    end
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (op_backlog.size() != 0 || in_valid || awaited.size() != 0);
  endtask

  task automatic set_sizes(input int d, input int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIM;
    cfg_data <= CFG_W'(d);
    @(negedge clk);
    cfg_index <= CFG_VOCAB;
    cfg_data <= CFG_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    gen_dim_raw = d;
    gen_vocab_raw = v;
    settings_used++;
  endtask

  initial begin
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 33;
    recv_idle_pct = 55;

    // directed: two rows of two elements, extreme values
    set_sizes(2, 2);
    queue_op(OP_WRITE_W, 8'd0, 6'd0, 16'sd32767);
    queue_op(OP_WRITE_W, 8'd0, 6'd1, -16'sd32768);
    queue_op(OP_WRITE_W, 8'd1, 6'd0, -16'sd32768);
    queue_op(OP_WRITE_W, 8'd1, 6'd1, -16'sd32768);
    queue_op(OP_LOAD_X, 8'd0, 6'd0, -16'sd32768);
    queue_op(OP_LOAD_X, 8'd0, 6'd1, -16'sd32768);
    queue_op(OP_LOGIT, 8'd1, 6'd0, 16'sd0);
    queue_op(OP_LOGIT, 8'd0, 6'd0, 16'sd0);
    queue_op(OP_WRITE_W, 8'd2, 6'd0, 16'sd1);
    queue_op(OP_WRITE_W, 8'd0, 6'd2, 16'sd1);
    queue_op(OP_UNDEF, 8'd255, 6'd63, -16'sd1);
    queue_op(OP_GRAD, 8'd1, 6'd0, -16'sd32768);
    queue_op(OP_GRAD, 8'd1, 6'd0, -16'sd32768);
    queue_op(OP_READ_DX, 8'd0, 6'd0, 16'sd0);
    queue_op(OP_READ_DX, 8'd0, 6'd63, 16'sd0);
    queue_op(OP_READ_WG, 8'd1, 6'd1, 16'sd0);
    queue_op(OP_READ_WG, 8'd255, 6'd0, 16'sd0);
    queue_op(OP_CLEAR_WG, 8'd0, 6'd0, 16'sd0);
    queue_op(OP_READ_WG, 8'd1, 6'd0, 16'sd0);
    queue_op(OP_GRAD, 8'd1, 6'd0, 16'sd32767);
    queue_op(OP_GRAD, 8'd1, 6'd0, 16'sd32767);
    queue_op(OP_GRAD, 8'd1, 6'd0, 16'sd32767);
    queue_op(OP_READ_WG, 8'd1, 6'd0, 16'sd0);
    queue_op(OP_LOAD_X, 8'd0, 6'd0, 16'sd1);
    queue_op(OP_READ_DX, 8'd0, 6'd0, 16'sd0);
    drain();

    set_sizes(8, 16);
    random_burst(450);
    drain();
    set_sizes(1, 1);
    random_burst(150);
    drain();

    send_idle_pct = 55;
    recv_idle_pct = 33;
    set_sizes(64, 256);
    random_burst(100);
    // sender holds off until every result is back
    drain();
    random_burst(100);
    drain();
    // out-of-range register values, clamped by the block
    set_sizes(0, 511);
    random_burst(150);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_sizes(127, 0);
    random_burst(100);
    drain();
    set_sizes(5, 200);
    random_burst(500);
    drain();
    set_sizes(16, 256);
    random_burst(250);
    drain();

    repeat (80) @(posedge clk);
    $display("checked %0d result beats (%0d logits) over %0d size settings", results_checked,
             logits_seen, settings_used);
    $display("%0d beats saturated, %0d rejected as bad index or op", sat_seen, bad_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/tvpm_pkg.sv
design/tvpm_ctrl.sv
design/tvpm_dp.sv
design/tied_vocab_projection_mac.sv
design/tvpm_chk.sv
sim/tb_tied_vocab_projection_mac.sv
